// ----- src/fsi_pkg.sv -----
// Shared types and constants for the free-space inventory.
// No dependencies.
`default_nettype none
package fsi_pkg;
  localparam int MAX_PAGES = 1024;

  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_UPDATE = 3'd1;
  localparam logic [2:0] CMD_FIND   = 3'd2;
  localparam logic [2:0] CMD_GROW   = 3'd3;
  localparam logic [2:0] CMD_ABSORB = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TOO_BIG  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  localparam logic [3:0] CLASS_EMPTY     = 4'd11;
  localparam logic [3:0] CLASS_NONE      = 4'd12;
  localparam logic [3:0] CLASS_INVENTORY = 4'd15;

  // Smallest class whose bound covers the request; CLASS_NONE means none.
  function automatic logic [3:0] start_class(input logic [15:0] req);
    logic [3:0] c;
    if (req == 16'd0) c = 4'd0;
    else if (req <= 16'd8) c = 4'd1;
    else if (req <= 16'd16) c = 4'd2;
    else if (req <= 16'd32) c = 4'd3;
    else if (req <= 16'd64) c = 4'd4;
    else if (req <= 16'd128) c = 4'd5;
    else if (req <= 16'd256) c = 4'd6;
    else if (req <= 16'd512) c = 4'd7;
    else if (req <= 16'd1024) c = 4'd8;
    else if (req <= 16'd2048) c = 4'd9;
    else if (req <= 16'd3072) c = 4'd10;
    else if (req <= 16'd4096) c = 4'd11;
    else c = CLASS_NONE;
    return c;
  endfunction

  // Largest class whose bound does not exceed the byte count.
  function automatic logic [3:0] class_of_bytes(input logic [15:0] fb);
    logic [3:0] c;
    if (fb >= 16'd4096) c = 4'd11;
    else if (fb >= 16'd3072) c = 4'd10;
    else if (fb >= 16'd2048) c = 4'd9;
    else if (fb >= 16'd1024) c = 4'd8;
    else if (fb >= 16'd512) c = 4'd7;
    else if (fb >= 16'd256) c = 4'd6;
    else if (fb >= 16'd128) c = 4'd5;
    else if (fb >= 16'd64) c = 4'd4;
    else if (fb >= 16'd32) c = 4'd3;
    else if (fb >= 16'd16) c = 4'd2;
    else if (fb >= 16'd8) c = 4'd1;
    else c = 4'd0;
    return c;
  endfunction

  typedef struct packed {
    logic scan_start;   // restart scan pointer at scan_base
    logic scan_step;    // advance pointer
    logic fill;         // write fill value at pointer
    logic fill_val_inv; // fill value: inventory instead of empty
    logic upd_write;    // write update class
    logic absorb_write; // write inventory class at best page
  } fsi_cmd_t;

  typedef struct packed {
    logic ptr_at_end;   // pointer is the last page of the range
    logic hit;          // a candidate page was recorded
  } fsi_stat_t;
endpackage
`default_nettype wire

// ----- src/fsi_datapath.sv -----
// Class memory, scan pointer and best-fit tracking for the inventory.
// Depends on fsi_pkg.
`default_nettype none
module fsi_datapath #(
  parameter int AW = 10,
  parameter int CW = 11
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fsi_pkg::fsi_cmd_t cmd_i,
  input  wire logic [CW-1:0]     scan_base_i,
  input  wire logic [CW-1:0]     scan_end_i,
  input  wire logic [AW-1:0]     upd_page_i,
  input  wire logic [3:0]        upd_class_i,
  input  wire logic [3:0]        min_class_i,
  input  wire logic              absorb_mode_i,
  output fsi_pkg::fsi_stat_t     stat_o,
  output logic [AW-1:0]          best_page_o,
  output logic [3:0]             best_class_o
);
  logic [3:0]    mem [fsi_pkg::MAX_PAGES];
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] rd_ptr_q;
  logic          rd_vld_q;
  logic [3:0]    rd_q;
  logic          hit_q, hit_d;
  logic [AW-1:0] best_q, best_d;
  logic [3:0]    bcls_q, bcls_d;
  logic          better;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_write) begin
      mem[upd_page_i] <= upd_class_i;
    end else if (cmd_i.absorb_write) begin
      mem[best_q] <= fsi_pkg::CLASS_INVENTORY;
    end else if (cmd_i.fill) begin
      mem[ptr_q[AW-1:0]] <= cmd_i.fill_val_inv ? fsi_pkg::CLASS_INVENTORY
                                              : fsi_pkg::CLASS_EMPTY;
    end
    rd_q <= mem[ptr_q[AW-1:0]];
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.scan_start) ptr_d = scan_base_i;
    else if (cmd_i.scan_step) ptr_d = ptr_q + CW'(1);
  end

  always_comb begin
    if (absorb_mode_i) begin
      better = !hit_q && rd_q == fsi_pkg::CLASS_EMPTY;
    end else begin
      better = rd_q >= min_class_i && rd_q <= fsi_pkg::CLASS_EMPTY &&
               (!hit_q || rd_q < bcls_q);
    end
    hit_d  = hit_q;
    best_d = best_q;
    bcls_d = bcls_q;
    if (cmd_i.scan_start) begin
      hit_d = 1'b0;
    end else if (rd_vld_q && better) begin
      hit_d  = 1'b1;
      best_d = rd_ptr_q[AW-1:0];
      bcls_d = rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      ptr_q    <= ptr_d;
      rd_vld_q <= cmd_i.scan_step && !cmd_i.fill;
      hit_q    <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= ptr_q;
    best_q   <= best_d;
    bcls_q   <= bcls_d;
  end

  assign stat_o.ptr_at_end = (ptr_q + CW'(1) >= scan_end_i);
  assign stat_o.hit        = hit_q;
  assign best_page_o       = best_q;
  assign best_class_o      = bcls_q;
endmodule
`default_nettype wire

// ----- src/fsi_ctrl.sv -----
// Command sequencer for the inventory: decode, scan control, result word.
// Depends on fsi_pkg.
`default_nettype none
module fsi_ctrl #(
  parameter int AW = 10,
  parameter int CW = 11
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [2:0]        command_i,
  input  wire logic [AW-1:0]     page_number_i,
  input  wire logic [15:0]       free_bytes_i,
  input  wire logic [15:0]       required_bytes_i,
  input  wire logic [CW-1:0]     added_pages_i,
  input  wire logic [CW-1:0]     initial_pages_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [AW-1:0]          page_index_o,
  output logic                   page_empty_o,
  output logic [2:0]             status_o,
  output fsi_pkg::fsi_cmd_t      cmd_o,
  input  wire fsi_pkg::fsi_stat_t stat_i,
  output logic [CW-1:0]          scan_base_o,
  output logic [CW-1:0]          scan_end_o,
  output logic [AW-1:0]          upd_page_o,
  output logic [3:0]             upd_class_o,
  output logic [3:0]             min_class_o,
  output logic                   absorb_mode_o,
  input  wire logic [AW-1:0]     best_page_i,
  input  wire logic [3:0]        best_class_i
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [CW:0] MAXP = (CW+1)'(fsi_pkg::MAX_PAGES);

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] base_q, base_d, end_q, end_d;
  logic [2:0]    op_q, op_d;
  logic [3:0]    minc_q, minc_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic          pemp_q, pemp_d;
  logic [2:0]    st_q, st_d;
  logic [3:0]    sc;
  logic [CW:0]   grow_sum;
  logic          fire;

  assign fire     = in_valid_i && in_ready_o;
  assign sc       = fsi_pkg::start_class(required_bytes_i);
  assign grow_sum = {1'b0, count_q} + {1'b0, added_pages_i};
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q; count_d = count_q; base_d = base_q; end_d = end_q;
    op_d = op_q; minc_d = minc_q; pidx_d = pidx_q; pemp_d = pemp_q; st_d = st_q;
    cmd_o = '0;
    upd_page_o  = page_number_i;
    upd_class_o = fsi_pkg::class_of_bytes(free_bytes_i);
    case (state_q)
      S_IDLE: begin
        if (fire) begin
          op_d = command_i; pidx_d = '0; pemp_d = 1'b0; st_d = fsi_pkg::ST_OK;
          state_d = S_OUT;
          case (command_i)
            fsi_pkg::CMD_INIT: begin
              if (initial_pages_i == '0 || {1'b0, initial_pages_i} > MAXP) begin
                st_d = fsi_pkg::ST_RANGE;
              end else begin
                base_d = '0; end_d = initial_pages_i;
                count_d = initial_pages_i;
                cmd_o.scan_start = 1'b1; state_d = S_FILL;
              end
            end
            fsi_pkg::CMD_UPDATE: begin
              if ({1'b0, page_number_i} >= count_q) st_d = fsi_pkg::ST_RANGE;
              else cmd_o.upd_write = 1'b1;
            end
            fsi_pkg::CMD_FIND: begin
              if (sc == fsi_pkg::CLASS_NONE) begin
                st_d = fsi_pkg::ST_TOO_BIG;
              end else if (count_q == '0) begin
                st_d = fsi_pkg::ST_FULL;
              end else begin
                minc_d = sc; base_d = '0; end_d = count_q;
                cmd_o.scan_start = 1'b1; state_d = S_SCAN;
              end
            end
            fsi_pkg::CMD_GROW: begin
              if (grow_sum > MAXP) begin
                st_d = fsi_pkg::ST_RANGE;
              end else if (added_pages_i != '0) begin
                base_d = count_q; end_d = grow_sum[CW-1:0];
                count_d = grow_sum[CW-1:0];
                cmd_o.scan_start = 1'b1; state_d = S_FILL;
              end
            end
            fsi_pkg::CMD_ABSORB: begin
              if (count_q <= CW'(1)) begin
                st_d = fsi_pkg::ST_OVERFLOW;
              end else begin
                base_d = CW'(1); end_d = count_q;
                cmd_o.scan_start = 1'b1; state_d = S_SCAN;
              end
            end
            default: st_d = fsi_pkg::ST_RANGE;
          endcase
        end
      end
      S_FILL: begin
        cmd_o.fill = 1'b1; cmd_o.scan_step = 1'b1;
        cmd_o.fill_val_inv = (op_q == fsi_pkg::CMD_INIT) && (base_q == '0) &&
                             !stat_i.hit && (count_q == end_q) && 1'b0;
        if (stat_i.ptr_at_end) state_d = S_OUT;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.ptr_at_end) state_d = S_TAIL;
      end
      S_TAIL: state_d = S_DONE;
      S_DONE: begin
        state_d = S_OUT;
        if (op_q == fsi_pkg::CMD_ABSORB) begin
          if (!stat_i.hit) begin
            st_d = fsi_pkg::ST_OVERFLOW;
          end else begin
            cmd_o.absorb_write = 1'b1; pidx_d = best_page_i;
          end
        end else begin
          if (!stat_i.hit || best_page_i == '0) begin
            st_d = fsi_pkg::ST_FULL;
          end else begin
            pidx_d = best_page_i;
            pemp_d = (best_class_i == fsi_pkg::CLASS_EMPTY);
          end
        end
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    // Page 0 of init gets the inventory class after the empty fill.
    if (state_q == S_FILL && stat_i.ptr_at_end && op_q == fsi_pkg::CMD_INIT) begin
      state_d = S_TAIL;
      op_d = fsi_pkg::CMD_UPDATE;
    end
    if (state_q == S_TAIL && op_q == fsi_pkg::CMD_UPDATE) begin
      upd_page_o = '0; upd_class_o = fsi_pkg::CLASS_INVENTORY;
      cmd_o.upd_write = 1'b1; state_d = S_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d; end_q <= end_d; op_q <= op_d; minc_q <= minc_d;
    pidx_q <= pidx_d; pemp_q <= pemp_d; st_q <= st_d;
  end

  assign scan_base_o   = base_d;
  assign scan_end_o    = end_q;
  assign min_class_o   = minc_q;
  assign absorb_mode_o = (op_q == fsi_pkg::CMD_ABSORB);
  assign page_index_o  = pidx_q;
  assign page_empty_o  = pemp_q;
  assign status_o      = st_q;
endmodule
`default_nettype wire

// ----- src/free_space_inventory_top.sv -----
// Top level of the free-space inventory: config register, sequencer, datapath.
// Depends on fsi_pkg, fsi_ctrl, fsi_datapath.
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready_i/o  tdata: command, page_number, free_bytes,
//                                          required_bytes, added_pages
// m_axis    out  m_axis_tvalid/tready_o/i  tdata: page_index, page_empty, status
// cfg       in   cfg_we_i                  cfg_wdata_i: initial_pages
//
// Update and bad commands go straight from the idle state to the result word.
// Find and absorb scan the class memory, one read per page in the range, then pass tail and done.
// Init and grow fill each page in turn; init then marks page 0 inventory in the tail state.
// Page count resets to zero; class memory holds no reset value.
// One word at a time; the input stalls until the result word is taken.
`default_nettype none
module free_space_inventory_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // command[2:0], page_number[12:3], free_bytes[28:13],
  // required_bytes[44:29], added_pages[55:45]
  input  wire logic [55:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // page_index[9:0], page_empty[10], status[13:11]
  output logic [15:0]      m_axis_tdata_o,
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_wdata_i
);
  localparam int AW = 10;
  localparam int CW = 11;

  logic [CW-1:0]      init_q;
  fsi_pkg::fsi_cmd_t  cmd;
  fsi_pkg::fsi_stat_t stat;
  logic [CW-1:0]      base, last;
  logic [AW-1:0]      upd_page, best_page, page_index;
  logic [3:0]         upd_class, min_class, best_class;
  logic               absorb_mode, page_empty;
  logic [2:0]         status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) init_q <= CW'(1024);
    else if (cfg_we_i) init_q <= cfg_wdata_i;
  end

  fsi_ctrl #(.AW(AW), .CW(CW)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .command_i(s_axis_tdata_i[2:0]), .page_number_i(s_axis_tdata_i[12:3]),
    .free_bytes_i(s_axis_tdata_i[28:13]), .required_bytes_i(s_axis_tdata_i[44:29]),
    .added_pages_i(s_axis_tdata_i[55:45]), .initial_pages_i(init_q),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .page_index_o(page_index), .page_empty_o(page_empty), .status_o(status),
    .cmd_o(cmd), .stat_i(stat), .scan_base_o(base), .scan_end_o(last),
    .upd_page_o(upd_page), .upd_class_o(upd_class), .min_class_o(min_class),
    .absorb_mode_o(absorb_mode), .best_page_i(best_page), .best_class_i(best_class)
  );

  fsi_datapath #(.AW(AW), .CW(CW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .scan_base_i(base), .scan_end_i(last),
    .upd_page_i(upd_page), .upd_class_i(upd_class), .min_class_i(min_class),
    .absorb_mode_i(absorb_mode), .stat_o(stat),
    .best_page_o(best_page), .best_class_o(best_class)
  );

  assign m_axis_tdata_o = {2'b00, status, page_empty, page_index};
endmodule
`default_nettype wire

// ----- src/fsi_checker.sv -----
// Port-level checker for the free-space inventory, bound to the top level.
// Depends on free_space_inventory_top ports only.
`default_nettype none
module fsi_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o
);
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[13:11] <= 3'd4) else $error("bad status");
  a_empty_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[10] |-> m_axis_tdata_o[13:11] == 3'd0 &&
    m_axis_tdata_o[9:0] != 10'd0) else $error("empty flag on failed find");
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("accepted two words");
endmodule

bind free_space_inventory_top fsi_checker u_fsi_checker (
  .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o,
  .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
);
`default_nettype wire
